@@ src/hdfm_pkg.sv @@
// Package for the heater drive fault monitor: item types, register codes,
// controller types and sizing constants. Depends on nothing.
package hdfm_pkg;

  // Field widths.
  localparam int unsigned SampleW = 10;
  localparam int unsigned TagW    = 8;
  localparam int unsigned RatioW  = 14;
  localparam int unsigned CountW  = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  // Length of the switch sample history.
  localparam int unsigned HistLen = 4;

  // Restoring divider: one quotient bit per step.
  localparam int unsigned DivSteps = RatioW;
  localparam int unsigned StepCntW = $clog2(DivSteps);

  // Register reset values.
  localparam logic [SampleW-1:0] SwitchLowThreshRst = SampleW'(401);
  localparam logic [RatioW-1:0]  OnRatioLimitRst    = RatioW'(7);
  localparam logic [CountW-1:0]  OnCountLimitRst    = CountW'(625);
  localparam logic [RatioW-1:0]  OffRatioLimitRst   = RatioW'(3);
  localparam logic [CountW-1:0]  OffCountLimitRst   = CountW'(625);

  // Register indexes on the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CfgSwitchLowThresh = 3'd0,
    CfgOnRatioLimit    = 3'd1,
    CfgOnCountLimit    = 3'd2,
    CfgOffRatioLimit   = 3'd3,
    CfgOffCountLimit   = 3'd4
  } cfg_idx_e;

  // One input item.
  typedef struct packed {
    logic               switch_status;
    logic [SampleW-1:0] switch_sample;
    logic [TagW-1:0]    sample_tag;
    logic [SampleW-1:0] heater_sample;
    logic [SampleW-1:0] supply_sample;
    logic               heater_enable;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic              drive_out;
    logic              switch_state;
    logic              fault_pulse;
    logic [RatioW-1:0] pin_ratio;
  } out_item_t;

  // Controller states.
  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StFinish
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

@@ src/hdfm_if.sv @@
// Valid/ready channel interfaces for input and result transactions.
// Depends on hdfm_pkg for the payload types.
interface hdfm_in_if;
  hdfm_pkg::in_item_t data;
  logic               valid;
  logic               ready;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hdfm_out_if;
  hdfm_pkg::out_item_t data;
  logic                valid;
  logic                ready;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/hdfm_ctrl.sv @@
// Controller of the heater drive fault monitor: sequences load, divide
// and commit. Depends on hdfm_pkg.
module hdfm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  hdfm_pkg::dp_status_t status_i,
  output hdfm_pkg::dp_cmd_t    cmd_o
);
  import hdfm_pkg::*;

  ctrl_state_e         state_q, state_d;
  logic [StepCntW-1:0] step_cnt_q, step_cnt_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (step_cnt_q == StepCntW'(DivSteps - 1)) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (!status_i.out_busy) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    step_cnt_d  = step_cnt_q;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        step_cnt_d = '0;
      end
      StDiv: begin
        cmd_o.step = 1'b1;
        step_cnt_d = step_cnt_q + 1'b1;
      end
      StFinish: begin
        cmd_o.commit = !status_i.out_busy;
      end
      default: ;
    endcase
  end

  // State and step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      step_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      step_cnt_q <= step_cnt_d;
    end
  end

  // The divider never runs past its last quotient bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDiv |-> step_cnt_q <= StepCntW'(DivSteps - 1))
    else $error("divider step count overran");

  // A finish always follows exactly the last divide step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFinish && $past(state_q) == StDiv |->
      $past(step_cnt_q) == StepCntW'(DivSteps - 1))
    else $error("finish entered before the quotient was complete");

endmodule

@@ src/hdfm_datapath.sv @@
// Datapath of the heater drive fault monitor: configuration registers,
// serial ratio divider, switch history, fault counters and result register.
// Depends on hdfm_pkg.
module hdfm_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hdfm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [hdfm_pkg::CfgW-1:0]    cfg_data_i,
  input  hdfm_pkg::in_item_t           in_data_i,
  input  hdfm_pkg::dp_cmd_t            cmd_i,
  output hdfm_pkg::dp_status_t         status_o,
  output logic                         out_valid_o,
  output hdfm_pkg::out_item_t          out_data_o,
  input  logic                         out_ready_i
);
  import hdfm_pkg::*;

  localparam logic [CountW-1:0] CountMax = '1;

  // Configuration registers.
  logic [SampleW-1:0] sw_low_thresh_q;
  logic [RatioW-1:0]  on_ratio_lim_q, off_ratio_lim_q;
  logic [CountW-1:0]  on_count_lim_q, off_count_lim_q;

  // Tick state.
  logic [HistLen-1:0] hist_q, hist_d;
  logic [TagW-1:0]    last_tag_q;
  logic [CountW-1:0]  on_cnt_q, on_cnt_d, off_cnt_q, off_cnt_d;
  logic               drive_q, drive_d, en_prev_q, sw_prev_q;

  // Captured item and divider.
  in_item_t           item_q;
  logic [SampleW-1:0] rem_q;
  logic [RatioW-1:0]  dvd_q;
  logic [SampleW:0]   rem_shift, rem_diff;
  logic [RatioW-1:0]  heater_x10;

  // Result register.
  logic      out_valid_q;
  out_item_t out_data_q, out_data_d;

  // Tick logic.
  logic              new_sample, press_bit, sw;
  logic [RatioW-1:0] ratio;
  logic              pulse;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_low_thresh_q <= SwitchLowThreshRst;
      on_ratio_lim_q  <= OnRatioLimitRst;
      on_count_lim_q  <= OnCountLimitRst;
      off_ratio_lim_q <= OffRatioLimitRst;
      off_count_lim_q <= OffCountLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSwitchLowThresh: sw_low_thresh_q <= cfg_data_i[SampleW-1:0];
        CfgOnRatioLimit:    on_ratio_lim_q  <= cfg_data_i[RatioW-1:0];
        CfgOnCountLimit:    on_count_lim_q  <= cfg_data_i[CountW-1:0];
        CfgOffRatioLimit:   off_ratio_lim_q <= cfg_data_i[RatioW-1:0];
        CfgOffCountLimit:   off_count_lim_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Heater sample times ten, as two shifts and an add.
  assign heater_x10 = {1'b0, in_data_i.heater_sample, 3'b000}
                    + {3'b000, in_data_i.heater_sample, 1'b0};

  // One restoring division step: the quotient bits shift into the dividend.
  assign rem_shift = {rem_q, dvd_q[RatioW-1]};
  assign rem_diff  = rem_shift - {1'b0, item_q.supply_sample};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
      rem_q  <= '0;
      dvd_q  <= heater_x10;
    end else if (cmd_i.step) begin
      if (!rem_diff[SampleW]) begin
        rem_q <= rem_diff[SampleW-1:0];
        dvd_q <= {dvd_q[RatioW-2:0], 1'b1};
      end else begin
        rem_q <= rem_shift[SampleW-1:0];
        dvd_q <= {dvd_q[RatioW-2:0], 1'b0};
      end
    end
  end

  // Switch qualification over the sample history.
  always_comb begin
    new_sample = item_q.sample_tag != last_tag_q;
    press_bit  = item_q.switch_sample <= sw_low_thresh_q;
    hist_d     = hist_q;
    sw         = item_q.switch_status;
    if (new_sample) begin
      if (HistLen > 1) begin
        hist_d = {hist_q[HistLen-2:0], press_bit};
      end else begin
        hist_d = HistLen'(press_bit);
      end
      if (hist_d == '1) begin
        sw = 1'b1;
      end else if (hist_d == '0) begin
        sw = 1'b0;
      end
    end
  end

  // A zero supply sample gives a zero ratio.
  assign ratio = (item_q.supply_sample == '0) ? '0 : dvd_q;

  // Fault counters, edge clear and drive update.
  always_comb begin
    on_cnt_d  = on_cnt_q;
    off_cnt_d = off_cnt_q;
    pulse     = 1'b0;
    drive_d   = drive_q;

    if (drive_q && item_q.heater_enable) begin
      if (ratio <= on_ratio_lim_q) begin
        if (on_cnt_q != CountMax) begin
          on_cnt_d = on_cnt_q + 1'b1;
          if (on_cnt_d == on_count_lim_q) begin
            pulse = 1'b1;
          end
        end
      end else begin
        on_cnt_d = '0;
      end
    end

    if (!drive_q && !item_q.heater_enable) begin
      if (ratio >= off_ratio_lim_q) begin
        if (off_cnt_q != CountMax) begin
          off_cnt_d = off_cnt_q + 1'b1;
          if (off_cnt_d == off_count_lim_q) begin
            pulse = 1'b1;
          end
        end
      end else begin
        off_cnt_d = '0;
      end
    end

    // A falling switch edge clears the on-fault count.
    if (sw_prev_q && !sw) begin
      on_cnt_d = '0;
    end

    if (en_prev_q != item_q.heater_enable) begin
      drive_d = item_q.heater_enable;
    end else begin
      drive_d = sw;
    end
  end

  always_comb begin
    out_data_d.drive_out    = drive_d;
    out_data_d.switch_state = sw;
    out_data_d.fault_pulse  = pulse;
    out_data_d.pin_ratio    = ratio;
  end

  // Tick state commits once per item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q     <= '0;
      last_tag_q <= '0;
      on_cnt_q   <= '0;
      off_cnt_q  <= '0;
      drive_q    <= 1'b0;
      en_prev_q  <= 1'b0;
      sw_prev_q  <= 1'b0;
    end else if (cmd_i.commit) begin
      hist_q     <= hist_d;
      last_tag_q <= item_q.sample_tag;
      on_cnt_q   <= on_cnt_d;
      off_cnt_q  <= off_cnt_d;
      drive_q    <= drive_d;
      en_prev_q  <= item_q.heater_enable;
      sw_prev_q  <= sw;
    end
  end

  // Result register: loaded on commit, emptied when the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_q <= out_data_d;
    end
  end

  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;

  // A commit never overwrites a result that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !out_valid_q || out_ready_i)
    else $error("result overwritten before transfer");

  // A commit always presents a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("committed result not presented");

  // A waiting result holds still until the sink takes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_data_q))
    else $error("waiting result changed before transfer");

endmodule

@@ src/heater_drive_fault_monitor_unit.sv @@
// Top level of the heater drive fault monitor: controller plus datapath.
// Depends on hdfm_pkg, hdfm_if, hdfm_ctrl and hdfm_datapath.
//
//   Channel   Direction   Handshake           Payload
//   in_if     sink        valid / ready       hdfm_pkg::in_item_t
//   out_if    source      valid / ready       hdfm_pkg::out_item_t
//   cfg       sink        cfg_we_i only       cfg_idx_i, cfg_data_i
//
// An item goes through an accept step, the bit-serial ratio divider (one
// quotient bit per cycle over RatioW bits), and a commit of the result.
// The next item is accepted as soon as the commit is done, while the
// result register may still be waiting for the sink. A stalled sink holds
// the block in its commit step. Reset is asynchronous and active low and
// restores all but the item, divider and result data registers at once.
module heater_drive_fault_monitor_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hdfm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [hdfm_pkg::CfgW-1:0]    cfg_data_i,
  hdfm_in_if.sink                      in_if,
  hdfm_out_if.source                   out_if
);
  import hdfm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;
  out_item_t  out_data;

  // Sequencer.
  hdfm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Arithmetic and state.
  hdfm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_if.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid),
    .out_data_o  (out_data),
    .out_ready_i (out_if.ready)
  );

  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;
  assign out_if.data  = out_data;

endmodule
